@@ rtl/antenna_status_frame_parser_macros.svh @@
// ----------------------------------------------------------------------------
// Antenna status frame parser assertion macros
// Shared property shorthands for the checker; clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef ANTENNA_STATUS_FRAME_PARSER_MACROS_SVH
`define ANTENNA_STATUS_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define ASFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("asfp assertion failed");

// next-cycle implication
`define ASFP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("asfp assertion failed");

`endif

@@ rtl/asfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Antenna status frame parser package
// Field widths, frame layout constants, status masks and the mask test.
// ----------------------------------------------------------------------------
package asfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ZoneW    = 9;
  localparam int unsigned AzW      = 26;
  localparam int unsigned ElW      = 23;
  localparam int unsigned NumStat  = 5;
  localparam int unsigned StatW    = NumStat * ByteW;
  localparam int unsigned NumCond  = 13;
  localparam int unsigned IdxW     = 5;

  // frame layout (byte positions)
  localparam logic [IdxW-1:0] PosStx     = 5'd0;
  localparam logic [IdxW-1:0] PosHdr     = 5'd1;
  localparam logic [IdxW-1:0] PosZone    = 5'd2;
  localparam logic [IdxW-1:0] PosAzFirst = 5'd3;
  localparam logic [IdxW-1:0] PosAzLast  = 5'd8;
  localparam logic [IdxW-1:0] PosElFirst = 5'd9;
  localparam logic [IdxW-1:0] PosElLast  = 5'd13;
  localparam logic [IdxW-1:0] PosStFirst = 5'd14;
  localparam logic [IdxW-1:0] PosLast    = 5'd19;

  localparam logic [ByteW-1:0] StxByte   = 8'h02;
  localparam logic [ByteW-1:0] EtxByte   = 8'h03;
  localparam logic [ByteW-1:0] HdrByte   = 8'h53;
  localparam logic [ByteW-1:0] DigitBias = 8'h30;

  localparam logic [ByteW-1:0] Mask38 = 8'h38;
  localparam logic [ByteW-1:0] Mask34 = 8'h34;
  localparam logic [ByteW-1:0] Mask32 = 8'h32;
  localparam logic [ByteW-1:0] Mask31 = 8'h31;

  typedef logic [NumStat-1:0][ByteW-1:0] status_t;

  function automatic logic has_bits(logic [ByteW-1:0] s, logic [ByteW-1:0] m);
    return (s & m) == m;
  endfunction

endpackage

@@ rtl/asfp_if.sv @@
// ----------------------------------------------------------------------------
// Antenna status frame parser channels
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface asfp_in_if;
  logic                             valid;
  logic                             ready;
  logic [asfp_pkg::ByteW-1:0]       rx_byte;
  logic                             frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface asfp_out_if;
  logic                             valid;
  logic                             ready;
  logic                             frame_ok;
  logic signed [asfp_pkg::ZoneW-1:0] zone;
  logic signed [asfp_pkg::AzW-1:0]  azimuth_mdeg;
  logic signed [asfp_pkg::ElW-1:0]  elevation_mdeg;
  logic [asfp_pkg::StatW-1:0]       status_bytes;
  logic [asfp_pkg::NumCond-1:0]     conditions;
  logic                             safety_fault;
  logic                             status_changed;

  modport source (output valid, frame_ok, zone, azimuth_mdeg, elevation_mdeg,
                  status_bytes, conditions, safety_fault, status_changed,
                  input ready);
  modport sink   (input valid, frame_ok, zone, azimuth_mdeg, elevation_mdeg,
                  status_bytes, conditions, safety_fault, status_changed,
                  output ready);
endinterface

@@ rtl/antenna_status_frame_parser.sv @@
// ----------------------------------------------------------------------------
// Antenna status frame parser
// Parses the 20-word antenna status reply and reports the stored status.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one reply byte per word plus a frame_start flag that forces
//   the word to byte position 0. Words are counted from there; the 20th word
//   of a reply produces one result word on out_o, the other words none.
//   The result is in the output register in the cycle after the 20th word
//   is accepted. Throughput: one word per cycle; the byte counter and
//   the shift-add digit accumulators update in the accept cycle.
//   If the receiver stalls, the pending result holds in the output register
//   and input words keep flowing; only a word arriving while the byte
//   counter stands at 19 waits until the output register is free.
//   A good frame (STX, 'S', ETX) stores zone, azimuth, elevation (in
//   millidegrees) and the five status bytes, moving the old status to the
//   previous copy; a bad frame leaves the store as it was.
//   Reset clears the counter, the store and the output valid.
// ----------------------------------------------------------------------------
module antenna_status_frame_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  asfp_in_if.sink           in_i,
  asfp_out_if.source        out_o
);

  logic [asfp_pkg::IdxW-1:0]          byte_index_q, byte_index_d, pos;
  logic                               fv_q, fv_d;
  logic signed [asfp_pkg::ZoneW-1:0]  zone_acc_q, zone_acc_d;
  logic signed [asfp_pkg::AzW-1:0]    az_acc_q, az_acc_d;
  logic signed [asfp_pkg::ElW-1:0]    el_acc_q, el_acc_d;
  asfp_pkg::status_t                  st_acc_q, st_acc_d;
  logic signed [asfp_pkg::ZoneW-1:0]  zone_q, zone_d;
  logic signed [asfp_pkg::AzW-1:0]    az_q, az_d;
  logic signed [asfp_pkg::ElW-1:0]    el_q, el_d;
  asfp_pkg::status_t                  st_q, st_d;
  asfp_pkg::status_t                  prev_q, prev_d;

  logic                               out_valid_q;
  logic                               ok_q;
  logic [asfp_pkg::NumCond-1:0]       cond_q, cond_d;
  logic                               fault_q, fault_d;
  logic                               changed_q;

  logic                               accept, is_last, ok, out_free;
  logic signed [asfp_pkg::ZoneW-1:0]  digit;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = out_free || (byte_index_q != asfp_pkg::PosLast);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    pos = in_i.frame_start ? asfp_pkg::PosStx : byte_index_q;
    if (pos > asfp_pkg::PosLast) begin
      pos = asfp_pkg::PosStx;
    end
  end

  assign is_last = (pos == asfp_pkg::PosLast);
  assign digit   = $signed({1'b0, in_i.rx_byte}) - $signed({1'b0, asfp_pkg::DigitBias});
  assign ok      = is_last && fv_q && (in_i.rx_byte == asfp_pkg::EtxByte);

  // per-position accumulate
  always_comb begin
    fv_d       = fv_q;
    zone_acc_d = zone_acc_q;
    az_acc_d   = az_acc_q;
    el_acc_d   = el_acc_q;
    st_acc_d   = st_acc_q;
    if (pos == asfp_pkg::PosStx) begin
      fv_d = (in_i.rx_byte == asfp_pkg::StxByte);
    end else if (pos == asfp_pkg::PosHdr) begin
      fv_d = fv_q && (in_i.rx_byte == asfp_pkg::HdrByte);
    end else if (pos == asfp_pkg::PosZone) begin
      zone_acc_d = digit;
    end else if (pos == asfp_pkg::PosAzFirst) begin
      az_acc_d = asfp_pkg::AzW'(digit);
    end else if (pos <= asfp_pkg::PosAzLast) begin
      az_acc_d = (az_acc_q <<< 3) + (az_acc_q <<< 1) + asfp_pkg::AzW'(digit);
    end else if (pos == asfp_pkg::PosElFirst) begin
      el_acc_d = asfp_pkg::ElW'(digit);
    end else if (pos <= asfp_pkg::PosElLast) begin
      el_acc_d = (el_acc_q <<< 3) + (el_acc_q <<< 1) + asfp_pkg::ElW'(digit);
    end else if (!is_last) begin
      for (int k = 0; k < asfp_pkg::NumStat; k++) begin
        if (pos == asfp_pkg::PosStFirst + asfp_pkg::IdxW'(k)) begin
          st_acc_d[k] = in_i.rx_byte;
        end
      end
    end
    if (is_last) begin
      fv_d = 1'b1;
    end
    byte_index_d = is_last ? asfp_pkg::PosStx : pos + 5'd1;
  end

  // store update on a good frame
  always_comb begin
    zone_d = ok ? zone_acc_q : zone_q;
    az_d   = ok ? az_acc_q   : az_q;
    el_d   = ok ? el_acc_q   : el_q;
    st_d   = ok ? st_acc_q   : st_q;
    prev_d = ok ? st_q       : prev_q;
  end

  always_comb begin
    cond_d[0]  = asfp_pkg::has_bits(st_d[0], asfp_pkg::Mask38);
    cond_d[1]  = asfp_pkg::has_bits(st_d[0], asfp_pkg::Mask34);
    cond_d[2]  = asfp_pkg::has_bits(st_d[0], asfp_pkg::Mask32);
    cond_d[3]  = asfp_pkg::has_bits(st_d[0], asfp_pkg::Mask31);
    cond_d[4]  = asfp_pkg::has_bits(st_d[1], asfp_pkg::Mask38);
    cond_d[5]  = asfp_pkg::has_bits(st_d[1], asfp_pkg::Mask34);
    cond_d[6]  = asfp_pkg::has_bits(st_d[1], asfp_pkg::Mask32);
    cond_d[7]  = asfp_pkg::has_bits(st_d[2], asfp_pkg::Mask38);
    cond_d[8]  = asfp_pkg::has_bits(st_d[2], asfp_pkg::Mask34);
    cond_d[9]  = asfp_pkg::has_bits(st_d[2], asfp_pkg::Mask32);
    cond_d[10] = asfp_pkg::has_bits(st_d[3], asfp_pkg::Mask34);
    cond_d[11] = asfp_pkg::has_bits(st_d[4], asfp_pkg::Mask34);
    cond_d[12] = asfp_pkg::has_bits(st_d[4], asfp_pkg::Mask32);
    fault_d    = cond_d[11] || cond_d[12] || asfp_pkg::has_bits(st_d[4], asfp_pkg::Mask31);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      fv_q         <= 1'b1;
      zone_q       <= '0;
      az_q         <= '0;
      el_q         <= '0;
      st_q         <= '0;
      prev_q       <= '0;
    end else if (accept) begin
      byte_index_q <= byte_index_d;
      fv_q         <= fv_d;
      zone_q       <= zone_d;
      az_q         <= az_d;
      el_q         <= el_d;
      st_q         <= st_d;
      prev_q       <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      zone_acc_q <= zone_acc_d;
      az_acc_q   <= az_acc_d;
      el_acc_q   <= el_acc_d;
      st_acc_q   <= st_acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && is_last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register: load only when the 20th word goes in (output then free)
  always_ff @(posedge clk_i) begin
    if (accept && is_last) begin
      ok_q      <= ok;
      cond_q    <= cond_d;
      fault_q   <= fault_d;
      changed_q <= (st_d != prev_d);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.frame_ok       = ok_q;
  assign out_o.zone           = zone_q;
  assign out_o.azimuth_mdeg   = az_q;
  assign out_o.elevation_mdeg = el_q;
  assign out_o.status_bytes   = st_q;
  assign out_o.conditions     = cond_q;
  assign out_o.safety_fault   = fault_q;
  assign out_o.status_changed = changed_q;

endmodule

@@ rtl/asfp_checker.sv @@
// ----------------------------------------------------------------------------
// Antenna status frame parser checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "antenna_status_frame_parser_macros.svh"

module asfp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          frame_ok_i,
  input logic [asfp_pkg::StatW-1:0]    status_bytes_i,
  input logic [asfp_pkg::NumCond-1:0]  conditions_i,
  input logic                          safety_fault_i
);

  logic fault_exp;
  logic cond0_exp;

  assign fault_exp = conditions_i[11] || conditions_i[12]
                  || asfp_pkg::has_bits(status_bytes_i[39:32], asfp_pkg::Mask31);
  assign cond0_exp = asfp_pkg::has_bits(status_bytes_i[7:0], asfp_pkg::Mask38);

  `ASFP_ASSERT_NXT(a_valid_hold, out_valid_i && !out_ready_i, out_valid_i)
  `ASFP_ASSERT_NXT(a_ok_hold, out_valid_i && !out_ready_i, $stable(frame_ok_i))
  `ASFP_ASSERT_IMP(a_fault_match, out_valid_i, safety_fault_i == fault_exp)
  `ASFP_ASSERT_IMP(a_cond0_match, out_valid_i, conditions_i[0] == cond0_exp)

endmodule

bind antenna_status_frame_parser asfp_checker u_asfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .frame_ok_i     (out_o.frame_ok),
  .status_bytes_i (out_o.status_bytes),
  .conditions_i   (out_o.conditions),
  .safety_fault_i (out_o.safety_fault)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Antenna status frame parser testbench
// Drives reply bytes into the parser and predicts every status report from a
// cycle-free model of the byte counter, digit accumulators and status store.
// Reports are compared whole, in order. Covers digit extremes, masked
// status flags, bad headers and trailers, restarts, unmarked frames and noise.
// Random gaps on both sides, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FrameLen    = int'(asfp_pkg::PosLast) + 1;
  localparam int RandomBytes = 1400;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 8;

  typedef logic [asfp_pkg::ByteW-1:0] frame_t [FrameLen];

  typedef struct packed {
    logic                               frame_ok;
    logic signed [asfp_pkg::ZoneW-1:0]  zone;
    logic signed [asfp_pkg::AzW-1:0]    azimuth_mdeg;
    logic signed [asfp_pkg::ElW-1:0]    elevation_mdeg;
    logic [asfp_pkg::StatW-1:0]         status_bytes;
    logic [asfp_pkg::NumCond-1:0]       conditions;
    logic                               safety_fault;
    logic                               status_changed;
  } status_report_t;

  typedef enum int {RxAlways, RxRandom, RxPattern, RxSlow} rx_pace_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  asfp_in_if  byte_ch ();
  asfp_out_if report_ch ();

  antenna_status_frame_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (report_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // parser state as predicted
  int unsigned                       cnt_pos    = 0;
  bit                                hdr_ok     = 1'b1;
  int                                acc_zone   = 0;
  int                                acc_az     = 0;
  int                                acc_el     = 0;
  asfp_pkg::status_t                 acc_stat   = '0;
  logic signed [asfp_pkg::ZoneW-1:0] kept_zone  = '0;
  logic signed [asfp_pkg::AzW-1:0]   kept_az    = '0;
  logic signed [asfp_pkg::ElW-1:0]   kept_el    = '0;
  asfp_pkg::status_t                 kept_stat  = '0;
  asfp_pkg::status_t                 prior_stat = '0;

  status_report_t pending_reports[$];
  int mismatch_cnt = 0;
  int bytes_sent   = 0;
  int reports_seen = 0;
  int good_frames  = 0;
  int bad_frames   = 0;

  // sender side
  int unsigned       tx_pos      = 0;
  int                burst_left  = 0;
  bit                no_gaps     = 1'b0;
  int                hold_req    = 0;
  asfp_pkg::status_t last_status = '0;

  function automatic logic covers(logic [asfp_pkg::ByteW-1:0] s,
                                  logic [asfp_pkg::ByteW-1:0] m);
    return (s & m) == m;
  endfunction

  function automatic bit predict_status_report(input logic [asfp_pkg::ByteW-1:0] b,
                                               input logic start,
                                               output status_report_t rpt);
    int unsigned pos;
    int          digit;
    logic        good;
    pos   = start ? 0 : cnt_pos;
    digit = int'(b) - int'(asfp_pkg::DigitBias);
    rpt   = '0;
    if (pos > asfp_pkg::PosLast) pos = 0;
    if (pos == asfp_pkg::PosStx) hdr_ok = (b == asfp_pkg::StxByte);
    else if (pos == asfp_pkg::PosHdr) hdr_ok = hdr_ok && (b == asfp_pkg::HdrByte);
    else if (pos == asfp_pkg::PosZone) acc_zone = digit;
    else if (pos == asfp_pkg::PosAzFirst) acc_az = digit;
    else if (pos <= asfp_pkg::PosAzLast) acc_az = acc_az * 10 + digit;
    else if (pos == asfp_pkg::PosElFirst) acc_el = digit;
    else if (pos <= asfp_pkg::PosElLast) acc_el = acc_el * 10 + digit;
    else if (pos < asfp_pkg::PosLast) acc_stat[pos - asfp_pkg::PosStFirst] = b;
    if (pos < asfp_pkg::PosLast) begin
      cnt_pos = pos + 1;
      return 1'b0;
    end
    cnt_pos = 0;
    good    = hdr_ok && (b == asfp_pkg::EtxByte);
    if (good) begin
      prior_stat = kept_stat;
      kept_zone  = acc_zone[asfp_pkg::ZoneW-1:0];
      kept_az    = acc_az[asfp_pkg::AzW-1:0];
      kept_el    = acc_el[asfp_pkg::ElW-1:0];
      kept_stat  = acc_stat;
    end
    hdr_ok = 1'b1;
    rpt.frame_ok       = good;
    rpt.zone           = kept_zone;
    rpt.azimuth_mdeg   = kept_az;
    rpt.elevation_mdeg = kept_el;
    rpt.status_bytes   = kept_stat;
    rpt.conditions     = {covers(kept_stat[4], asfp_pkg::Mask32),
                          covers(kept_stat[4], asfp_pkg::Mask34),
                          covers(kept_stat[3], asfp_pkg::Mask34),
                          covers(kept_stat[2], asfp_pkg::Mask32),
                          covers(kept_stat[2], asfp_pkg::Mask34),
                          covers(kept_stat[2], asfp_pkg::Mask38),
                          covers(kept_stat[1], asfp_pkg::Mask32),
                          covers(kept_stat[1], asfp_pkg::Mask34),
                          covers(kept_stat[1], asfp_pkg::Mask38),
                          covers(kept_stat[0], asfp_pkg::Mask31),
                          covers(kept_stat[0], asfp_pkg::Mask32),
                          covers(kept_stat[0], asfp_pkg::Mask34),
                          covers(kept_stat[0], asfp_pkg::Mask38)};
    // S5 with 0x31 has no condition bit; it only shows up as a fault
    rpt.safety_fault   = covers(kept_stat[4], asfp_pkg::Mask34) ||
                         covers(kept_stat[4], asfp_pkg::Mask32) ||
                         covers(kept_stat[4], asfp_pkg::Mask31);
    rpt.status_changed = (kept_stat != prior_stat);
    return 1'b1;
  endfunction

  function automatic string show_report(status_report_t r);
    return $sformatf("ok=%0b zone=%0d az=%0d el=%0d st=%010h cond=%04h fault=%0b chg=%0b",
                     r.frame_ok, r.zone, r.azimuth_mdeg, r.elevation_mdeg,
                     r.status_bytes, r.conditions, r.safety_fault, r.status_changed);
  endfunction

  // predict on every accepted input word
  always @(posedge clk_i) begin : byte_monitor
    status_report_t rpt;
    if (rst_ni && byte_ch.valid && byte_ch.ready) begin
      if (predict_status_report(byte_ch.rx_byte, byte_ch.frame_start, rpt)) begin
        pending_reports.push_back(rpt);
        if (rpt.frame_ok) good_frames++;
        else bad_frames++;
      end
    end
  end

  always @(posedge clk_i) begin : report_checker
    status_report_t got;
    status_report_t want;
    if (rst_ni && report_ch.valid && report_ch.ready) begin
      reports_seen++;
      got.frame_ok       = report_ch.frame_ok;
      got.zone           = report_ch.zone;
      got.azimuth_mdeg   = report_ch.azimuth_mdeg;
      got.elevation_mdeg = report_ch.elevation_mdeg;
      got.status_bytes   = report_ch.status_bytes;
      got.conditions     = report_ch.conditions;
      got.safety_fault   = report_ch.safety_fault;
      got.status_changed = report_ch.status_changed;
      if (pending_reports.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected report: %s", show_report(got));
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("report differs at %0t", $realtime);
            $display("  expected %s", show_report(want));
            $display("  actual   %s", show_report(got));
          end
        end
      end
    end
  end

  // output ready: changing stall patterns, plus a long hold-off on request
  initial begin : rx_pace
    rx_pace_e pace;
    int pace_left;
    int hold_left;
    int hold_seen;
    int phase;
    pace      = RxAlways;
    pace_left = 0;
    hold_left = 0;
    hold_seen = 0;
    phase     = 0;
    report_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        report_ch.ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldCycles - 1;
        report_ch.ready <= 1'b0;
      end else begin
        if (pace_left == 0) begin
          pace      = rx_pace_e'($urandom_range(0, 3));
          pace_left = $urandom_range(20, 200);
        end
        pace_left--;
        case (pace)
          RxAlways:  report_ch.ready <= 1'b1;
          RxRandom:  report_ch.ready <= ($urandom_range(0, 2) != 0);
          RxPattern: report_ch.ready <= ((phase % 5) < 3);
          default:   report_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [asfp_pkg::ByteW-1:0] b, input logic start);
    int gap;
    byte_ch.valid       <= 1'b1;
    byte_ch.rx_byte     <= b;
    byte_ch.frame_start <= start;
    do @(posedge clk_i); while (!byte_ch.ready);
    bytes_sent++;
    tx_pos = start ? 1 : tx_pos + 1;
    if (tx_pos == FrameLen) tx_pos = 0;
    if (!no_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(0, 30);
        byte_ch.valid       <= 1'b0;
        byte_ch.rx_byte     <= 8'($urandom_range(0, 255));
        byte_ch.frame_start <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // mark byte 0 when asked to, and whenever the count is not aligned to a frame boundary
  task automatic send_frame(input frame_t f, input int len, input bit mark);
    bit first_mark;
    first_mark = mark || (tx_pos != 0);
    for (int i = 0; i < len; i++) send_byte(f[i], (i == 0) ? first_mark : 1'b0);
  endtask

  function automatic void fill_frame(output frame_t f, input int noise_pct,
                                     input bit keep_status);
    logic [asfp_pkg::ByteW-1:0] s;
    f[asfp_pkg::PosStx] = asfp_pkg::StxByte;
    f[asfp_pkg::PosHdr] = asfp_pkg::HdrByte;
    for (int i = asfp_pkg::PosZone; i <= asfp_pkg::PosElLast; i++) begin
      if ($urandom_range(0, 99) < noise_pct) f[i] = 8'($urandom_range(0, 255));
      else f[i] = asfp_pkg::DigitBias + 8'($urandom_range(0, 9));
    end
    for (int i = 0; i < asfp_pkg::NumStat; i++) begin
      s = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
        0: s = s | asfp_pkg::Mask38;
        1: s = s | asfp_pkg::Mask34;
        2: s = s | asfp_pkg::Mask32;
        3: s = s | asfp_pkg::Mask31;
        default: ;
      endcase
      if (!keep_status) last_status[i] = s;
      f[int'(asfp_pkg::PosStFirst) + i] = last_status[i];
    end
    f[asfp_pkg::PosLast] = asfp_pkg::EtxByte;
  endfunction

  task automatic test_digit_extremes();
    frame_t f;
    fill_frame(f, 0, 1'b0);
    for (int i = asfp_pkg::PosZone; i < asfp_pkg::PosLast; i++) f[i] = 8'hFF;
    f[asfp_pkg::PosLast - 1] = asfp_pkg::Mask31;
    send_frame(f, FrameLen, 1'b1);
  endtask

  task automatic test_restart_mid_frame();
    frame_t f;
    fill_frame(f, 0, 1'b0);
    send_frame(f, 3, 1'b1);
    for (int i = asfp_pkg::PosZone; i < asfp_pkg::PosLast; i++) f[i] = 8'h00;
    send_frame(f, FrameLen, 1'b1);
  endtask

  task automatic test_unmarked_bad_header();
    frame_t f;
    fill_frame(f, 0, 1'b0);
    f[asfp_pkg::PosStx] = 8'hFD;
    send_frame(f, FrameLen, 1'b0);
  endtask

  task automatic test_output_backpressure();
    frame_t f;
    no_gaps = 1'b1;
    hold_req++;
    repeat (3) begin
      fill_frame(f, 10, 1'b0);
      send_frame(f, FrameLen, 1'b1);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    frame_t f;
    int stop_at;
    int kind;
    int p;
    logic [asfp_pkg::ByteW-1:0] orig;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      kind    = $urandom_range(0, 99);
      fill_frame(f, 15, $urandom_range(0, 3) == 0);
      if (kind < 60) begin
        send_frame(f, FrameLen, 1'($urandom_range(0, 1)));
      end else if (kind < 78) begin
        case ($urandom_range(0, 2))
          0:       p = asfp_pkg::PosStx;
          1:       p = asfp_pkg::PosHdr;
          default: p = asfp_pkg::PosLast;
        endcase
        orig = f[p];
        do f[p] = 8'($urandom_range(0, 255)); while (f[p] == orig);
        send_frame(f, FrameLen, 1'($urandom_range(0, 1)));
      end else if (kind < 90) begin
        // cut short; the next frame restarts with a start mark
        send_frame(f, $urandom_range(1, FrameLen - 1), 1'b1);
      end else begin
        repeat ($urandom_range(1, 25))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    byte_ch.valid       = 1'b0;
    byte_ch.rx_byte     = '0;
    byte_ch.frame_start = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_digit_extremes();
    test_restart_mid_frame();
    test_unmarked_bad_header();
    test_output_backpressure();
    test_random_traffic();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d bytes, checked %0d reports (%0d stored frames, %0d rejected)",
             bytes_sent, reports_seen, good_frames, bad_frames);
    $display("included restarts, unmarked frames, noise and a %0d-cycle output hold-off",
             HoldCycles);
    if (mismatch_cnt == 0) begin
      $display("antenna_status_frame_parser: match");
    end else begin
      $display("antenna_status_frame_parser: mismatch");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("timeout with %0d reports outstanding", pending_reports.size());
    $display("antenna_status_frame_parser: mismatch");
    $finish;
  end

endmodule
